[hw/rtl/arp_pkg.sv]
// shared types, codes and helpers for the relocation patcher
package arp_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned TypeW = 8;

  // relocation type codes
  localparam logic [TypeW-1:0] TY_ABS32    = 8'd2;
  localparam logic [TypeW-1:0] TY_THM_CALL = 8'd10;
  localparam logic [TypeW-1:0] TY_CALL     = 8'd28;
  localparam logic [TypeW-1:0] TY_JUMP24   = 8'd29;
  localparam logic [TypeW-1:0] TY_TARGET1  = 8'd38;
  localparam logic [TypeW-1:0] TY_TLS_LE32 = 8'd108;

  localparam logic [WordW-1:0] TlsOffset   = 32'd8;
  localparam logic [WordW-1:0] ThmLimit    = 32'h003F_FFFF;
  localparam logic [WordW-1:0] ArmLimit    = 32'h007F_FFFF;
  localparam logic [WordW-1:0] BlxOpcode   = 32'hFA00_0000;
  localparam logic [15:0]      ThmHiPrefix = 16'hF000;
  localparam logic [15:0]      ThmBlxLo    = 16'hE800;
  localparam logic [15:0]      ThmBlLo     = 16'hF800;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_THUMB   = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  // captured relocation, with the branch address already formed
  typedef struct packed {
    logic [TypeW-1:0] reloc_type;
    logic [WordW-1:0] addr;
    logic             sym_external;
    logic [WordW-1:0] sym_value;
    logic [WordW-1:0] old_word;
  } reloc_t;

  typedef struct packed {
    logic             write_word;
    logic [WordW-1:0] new_word;
    status_t          status;
  } patch_t;

  // two's complement v lies in (-lim, lim]
  function automatic logic in_range(input logic [WordW-1:0] v, input logic [WordW-1:0] lim);
    logic [WordW-1:0] neg;
    neg = WordW'(0) - v;
    if (!v[WordW-1]) begin
      in_range = (v <= lim);
    end else begin
      in_range = (neg < lim);
    end
  endfunction

endpackage

[hw/rtl/arp_patch.sv]
// combinational patch logic for one captured relocation
module arp_patch (
  input  arp_pkg::reloc_t     rel,
  input  logic [31:0]         load_base,
  output arp_pkg::patch_t     res
);
  import arp_pkg::*;

  logic             to_arm;
  logic [WordW-1:0] diff;
  logic [WordW-1:0] bias;
  logic [WordW-1:0] j;
  logic             thm_ok;
  logic             arm_ok;
  logic [15:0]      h0;
  logic [15:0]      h1;

  assign to_arm = ~rel.sym_value[0];
  assign diff   = rel.sym_value - rel.addr;

  always_comb begin
    bias = 32'd6;
    if (rel.reloc_type == TY_THM_CALL) begin
      bias = to_arm ? 32'd2 : 32'd4;
    end else if (rel.reloc_type == TY_CALL && !to_arm) begin
      bias = 32'd8;
    end
  end

  assign j      = diff - bias;
  assign thm_ok = in_range(j, ThmLimit);
  assign arm_ok = in_range(j, ArmLimit);
  assign h0     = ThmHiPrefix | {5'd0, j[22:12]};
  assign h1     = to_arm ? (ThmBlxLo | {5'd0, j[11:2], 1'b0})
                         : (ThmBlLo | {5'd0, j[11:1]});

  always_comb begin
    res.write_word = 1'b0;
    res.new_word   = rel.old_word;
    res.status     = ST_OK;
    unique case (rel.reloc_type)
      TY_ABS32, TY_TARGET1: begin
        res.new_word   = rel.sym_external ? rel.sym_value : rel.old_word + load_base;
        res.write_word = 1'b1;
      end
      TY_THM_CALL: begin
        if (rel.sym_external) begin
          if (!thm_ok) begin
            res.status = ST_RANGE;
          end else begin
            res.new_word   = {h1, h0};
            res.write_word = 1'b1;
          end
        end
      end
      TY_JUMP24: begin
        if (rel.sym_external) begin
          if (!to_arm) begin
            res.status = ST_THUMB;
          end else if (!arm_ok) begin
            res.status = ST_RANGE;
          end else begin
            res.new_word   = {rel.old_word[31:24], j[25:2]};
            res.write_word = 1'b1;
          end
        end
      end
      TY_CALL: begin
        if (rel.sym_external) begin
          if (!arm_ok) begin
            res.status = ST_RANGE;
          end else if (to_arm) begin
            res.new_word   = {rel.old_word[31:24], j[25:2]};
            res.write_word = 1'b1;
          end else begin
            res.new_word   = BlxOpcode | {7'd0, j[1], j[25:2]};
            res.write_word = 1'b1;
          end
        end
      end
      TY_TLS_LE32: begin
        res.new_word   = rel.sym_value + TlsOffset;
        res.write_word = 1'b1;
      end
      default: begin
        res.status = ST_UNKNOWN;
      end
    endcase
  end

endmodule

[hw/rtl/arm_relocation_patcher_top.sv]
// top level of the relocation patcher: capture register, patch logic, result register
//
// Patches one ARM ELF relocation per transfer. Each input transfer carries the
// relocation type, the target offset from the load base, the symbol's external
// flag and value, and the word currently at the target; each output transfer
// returns the patched word, a write flag and a status (ok, out of range, jump
// to Thumb, unknown type). Exactly one result comes out per input, in order.
// The block is a two-register pipeline: the input register also forms the
// branch address load_base + target_offset, and the combinational patch logic
// (a subtract of address and a small bias, a range compare and bit packing)
// feeds the result register. out_valid is registered from the capture stage's
// valid flag, so each item passes the capture register and then the result
// register, and a new item is taken every cycle while the output side keeps
// up; the capture register can still take an item while a result waits under
// out_stall, so in_stall only rises once both registers hold data and the
// result is stalled. load_base is written through the cfg channel, which is
// always ready; write it only while no items are in flight.
module arm_relocation_patcher_top (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [31:0]           cfg_data,
  // relocation input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            reloc_type,
  input  logic [31:0]           target_offset,
  input  logic                  sym_external,
  input  logic [31:0]           sym_value,
  input  logic [31:0]           old_word,
  // result output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  write_word,
  output logic [31:0]           new_word,
  output logic [1:0]            status
);
  import arp_pkg::*;

  logic [WordW-1:0] load_base;
  logic             s1_valid;
  reloc_t           s1;
  patch_t           s2;
  patch_t           s2_next;
  logic             s2_free;
  logic             in_take;

  // the single register is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      load_base <= cfg_data;
    end
  end

  // result register frees up when empty or being taken this cycle
  assign s2_free  = !out_valid || !out_stall;
  // capture register can take a new item when empty or handing its item on
  assign in_stall = s1_valid && !s2_free;
  assign in_take  = in_valid && !in_stall;

  // capture stage, branch address formed on the way in
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s2_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1.reloc_type   <= reloc_type;
      s1.addr         <= load_base + target_offset;
      s1.sym_external <= sym_external;
      s1.sym_value    <= sym_value;
      s1.old_word     <= old_word;
    end
  end

  arp_patch u_patch (
    .rel       (s1),
    .load_base (load_base),
    .res       (s2_next)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2 <= s2_next;
    end
  end

  assign write_word = s2.write_word;
  assign new_word   = s2.new_word;
  assign status     = s2.status;

  // any error status means the word is left untouched
  a_err_no_write : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> !write_word)
    else $error("error status with write flag set");

  // input side only stalls when the capture register holds an item
  a_stall_held : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a full pipeline");

  // a stalled result leaves the capture stage holding its item
  a_hold_s1 : assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |=> s1_valid)
    else $error("capture stage item lost under output stall");

endmodule
